// ===== rtl/ipv4p_pkg.sv =====
// ipv4p_pkg: types, character codes and helpers shared by the IPv4 text parser
// used by every module of the parser; depends on nothing

`timescale 1ns / 1ps

package ipv4p_pkg;

  // input beat: one character and the start-of-string flag
  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } in_t;

  // output beat: ok flag and parsed address
  typedef struct packed {
    logic        ok;
    logic [31:0] address;
  } out_t;

  // character classes produced by the front end
  typedef enum logic [2:0] {
    ClsDigit     = 3'd0,
    ClsHexLetter = 3'd1,
    ClsX         = 3'd2,
    ClsDot       = 3'd3,
    ClsEnd       = 3'd4,
    ClsOther     = 3'd5
  } char_class_e;

  // parser phases
  typedef enum logic [1:0] {
    PhFinished  = 2'd0,
    PhPartStart = 2'd1,
    PhAfterZero = 2'd2,
    PhDigits    = 2'd3
  } phase_e;

  // radix of the current part
  typedef enum logic [1:0] {
    RxDec = 2'd0,
    RxOct = 2'd1,
    RxHex = 2'd2
  } radix_e;

  // classified character as it sits in the queue
  typedef struct packed {
    char_class_e cls;
    logic [3:0]  val;
    logic        first;
  } item_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // character codes
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChLowX  = 8'h78;

  // low nibble of a..f / A..F plus this gives 10..15
  localparam logic [3:0] HexLetterOffset = 4'd9;

  // range limits of the last part
  localparam logic [31:0] Max24 = 32'h00ff_ffff;
  localparam logic [31:0] Max16 = 32'h0000_ffff;
  localparam logic [31:0] Max8  = 32'h0000_00ff;

  // number of leading parts that can be stored
  localparam logic [1:0] MaxParts = 2'd3;

  // accumulator times radix, built from shifts and one add
  function automatic logic [31:0] scale_acc(logic [31:0] acc, radix_e rx);
    logic [31:0] res;
    case (rx)
      RxOct:   res = acc << 3;
      RxHex:   res = acc << 4;
      default: res = (acc << 3) + (acc << 1);
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/ipv4p_front.sv =====
// ipv4p_front: accepts character beats and classifies them for the parser
// depends on ipv4p_pkg; feeds ipv4p_fifo

`timescale 1ns / 1ps

module ipv4p_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ipv4p_pkg::in_t    in_data_i,
  input  ipv4p_pkg::q_stat_t q_stat_i,
  output logic              push_o,
  output ipv4p_pkg::item_t  item_o
);

  // accept whenever the queue has room
  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  // character classification
  always_comb begin
    item_o.first = in_data_i.first;
    item_o.val   = '0;
    item_o.cls   = ipv4p_pkg::ClsOther;
    if (in_data_i.ch inside {[ipv4p_pkg::ChZero:ipv4p_pkg::ChNine]}) begin
      item_o.cls = ipv4p_pkg::ClsDigit;
      item_o.val = in_data_i.ch[3:0];
    end else if (in_data_i.ch inside {[ipv4p_pkg::ChLowA:ipv4p_pkg::ChLowF],
                                      [ipv4p_pkg::ChUpA:ipv4p_pkg::ChUpF]}) begin
      item_o.cls = ipv4p_pkg::ClsHexLetter;
      item_o.val = in_data_i.ch[3:0] + ipv4p_pkg::HexLetterOffset;
    end else if (in_data_i.ch inside {ipv4p_pkg::ChLowX, ipv4p_pkg::ChUpX}) begin
      item_o.cls = ipv4p_pkg::ClsX;
    end else if (in_data_i.ch == ipv4p_pkg::ChDot) begin
      item_o.cls = ipv4p_pkg::ClsDot;
    end else if (in_data_i.ch inside {ipv4p_pkg::ChNul, ipv4p_pkg::ChSpace}) begin
      item_o.cls = ipv4p_pkg::ClsEnd;
    end
  end

endmodule

// ===== rtl/ipv4p_fifo.sv =====
// ipv4p_fifo: short queue of classified characters between front and back
// depends on ipv4p_pkg

`timescale 1ns / 1ps

module ipv4p_fifo #(
  parameter int Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ipv4p_pkg::item_t   item_i,
  input  logic               pop_i,
  output ipv4p_pkg::item_t   item_o,
  output ipv4p_pkg::q_stat_t q_stat_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ipv4p_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  // status
  assign q_stat_o.full  = (cnt_q == CntW'(Depth));
  assign q_stat_o.empty = (cnt_q == '0);
  assign item_o         = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/ipv4p_back.sv =====
// ipv4p_back: parser state machine and output register
// depends on ipv4p_pkg; takes classified beats from ipv4p_fifo

`timescale 1ns / 1ps

module ipv4p_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ipv4p_pkg::item_t   item_i,
  input  ipv4p_pkg::q_stat_t q_stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ipv4p_pkg::out_t    out_data_o
);

  ipv4p_pkg::phase_e phase_q, phase_d, ph;
  ipv4p_pkg::radix_e radix_q, radix_d, rx;
  logic [31:0]       acc_q, acc_d, a;
  logic [1:0]        cnt_q, cnt_d, n;
  logic [31:0]       parts_q [3];
  logic              part_we;
  logic              run_digits;
  logic              emit;
  ipv4p_pkg::out_t   res;
  logic              out_valid_q;
  ipv4p_pkg::out_t   out_q;
  logic              ready;
  logic              fits;
  logic [31:0]       combined;

  // take a beat when the output register is free or being drained
  assign ready       = !out_valid_q || !out_stall_i;
  assign pop_o       = !q_stat_i.empty && ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // last part range check and merge with stored parts
  always_comb begin
    case (n)
      2'd0: begin
        fits     = 1'b1;
        combined = a;
      end
      2'd1: begin
        fits     = (a <= ipv4p_pkg::Max24);
        combined = a | (parts_q[0] << 24);
      end
      2'd2: begin
        fits     = (a <= ipv4p_pkg::Max16);
        combined = a | (parts_q[0] << 24) | (parts_q[1] << 16);
      end
      default: begin
        fits     = (a <= ipv4p_pkg::Max8);
        combined = a | (parts_q[0] << 24) | (parts_q[1] << 16) | (parts_q[2] << 8);
      end
    endcase
  end

  // next state for one beat
  always_comb begin
    ph         = phase_q;
    rx         = radix_q;
    a          = acc_q;
    n          = cnt_q;
    phase_d    = phase_q;
    radix_d    = radix_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    part_we    = 1'b0;
    run_digits = 1'b0;
    emit       = 1'b0;
    res        = '0;
    if (pop_o) begin
      // a flagged character restarts the parser
      if (item_i.first) begin
        ph = ipv4p_pkg::PhPartStart;
        rx = ipv4p_pkg::RxDec;
        a  = '0;
        n  = '0;
      end
      phase_d = ph;
      radix_d = rx;
      acc_d   = a;
      cnt_d   = n;
      case (ph)
        ipv4p_pkg::PhFinished: begin
          phase_d = ipv4p_pkg::PhFinished;
        end
        ipv4p_pkg::PhPartStart: begin
          if (item_i.cls != ipv4p_pkg::ClsDigit) begin
            emit    = 1'b1;
            phase_d = ipv4p_pkg::PhFinished;
          end else if (item_i.val == 4'd0) begin
            acc_d   = '0;
            phase_d = ipv4p_pkg::PhAfterZero;
          end else begin
            acc_d   = {28'd0, item_i.val};
            radix_d = ipv4p_pkg::RxDec;
            phase_d = ipv4p_pkg::PhDigits;
          end
        end
        ipv4p_pkg::PhAfterZero: begin
          if (item_i.cls == ipv4p_pkg::ClsX) begin
            radix_d = ipv4p_pkg::RxHex;
            acc_d   = '0;
            phase_d = ipv4p_pkg::PhDigits;
          end else begin
            rx         = ipv4p_pkg::RxOct;
            radix_d    = ipv4p_pkg::RxOct;
            phase_d    = ipv4p_pkg::PhDigits;
            run_digits = 1'b1;
          end
        end
        default: begin
          run_digits = 1'b1;
        end
      endcase

      // digits of a part, separators and endings
      if (run_digits) begin
        case (item_i.cls)
          ipv4p_pkg::ClsDigit: begin
            acc_d = ipv4p_pkg::scale_acc(a, rx) + {28'd0, item_i.val};
          end
          ipv4p_pkg::ClsHexLetter: begin
            if (rx == ipv4p_pkg::RxHex) begin
              acc_d = {a[27:0], item_i.val};
            end else begin
              emit    = 1'b1;
              phase_d = ipv4p_pkg::PhFinished;
            end
          end
          ipv4p_pkg::ClsDot: begin
            if (n == ipv4p_pkg::MaxParts) begin
              emit    = 1'b1;
              phase_d = ipv4p_pkg::PhFinished;
            end else begin
              part_we = 1'b1;
              cnt_d   = n + 1'b1;
              acc_d   = '0;
              radix_d = ipv4p_pkg::RxDec;
              phase_d = ipv4p_pkg::PhPartStart;
            end
          end
          ipv4p_pkg::ClsEnd: begin
            emit        = 1'b1;
            phase_d     = ipv4p_pkg::PhFinished;
            res.ok      = fits;
            res.address = fits ? combined : '0;
          end
          default: begin
            emit    = 1'b1;
            phase_d = ipv4p_pkg::PhFinished;
          end
        endcase
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ipv4p_pkg::PhFinished;
      radix_q <= ipv4p_pkg::RxDec;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      radix_q <= radix_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

  // stored leading parts
  always_ff @(posedge clk_i) begin
    if (part_we) begin
      parts_q[n] <= a;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && emit) begin
      out_q <= res;
    end
  end

endmodule

// ===== rtl/ipv4_text_address_parser_core.sv =====
// ipv4_text_address_parser_core: top level of the dotted IPv4 text parser
// depends on ipv4p_pkg, ipv4p_front, ipv4p_fifo and ipv4p_back
//
// Usage:
//   The input channel carries one character per beat (in_data_i.ch) with a
//   flag (in_data_i.first) that marks the first character of a new string.
//   The output channel carries one beat per finished string: ok and the
//   address, first dotted part in bits 31..24, zero when ok is low.
//   A string ends at NUL or space (valid) or at any character that cannot
//   continue it (failure); characters after that are dropped until the next
//   flagged character, and a string cut short by a new flag gives no beat.
//   Throughput is one character per cycle unless the output stalls; the parser
//   updates its part accumulator with a shift-and-add for each character.
//   out_valid_o rises after the ending character is accepted: the character
//   is written into the character queue, and the parser loads the output
//   register as it takes the character from the queue.
//   When the receiver stalls, the result holds in the output register, the
//   parser stops and the queue (QueueDepth beats) fills before in_stall_o
//   rises. Reset clears the queue and the output valid flag and leaves the
//   parser waiting for a flagged character.

`timescale 1ns / 1ps

module ipv4_text_address_parser_core #(
  parameter int QueueDepth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ipv4p_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ipv4p_pkg::out_t out_data_o
);

  logic               push;
  logic               pop;
  ipv4p_pkg::item_t   front_item;
  ipv4p_pkg::item_t   queue_item;
  ipv4p_pkg::q_stat_t q_stat;

  // accept and classify
  ipv4p_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .item_o     (front_item)
  );

  // classified character queue
  ipv4p_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .item_o   (queue_item),
    .q_stat_o (q_stat)
  );

  // parser and output register
  ipv4p_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (queue_item),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // a failed string always reports a zero address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |-> out_data_o.address == '0)
    else $error("failed result with nonzero address");

  // a new result only follows a beat taken from the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(pop))
    else $error("result without a parsed character");

  // queue is never full and empty at once, and never popped when empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty) && !(pop && q_stat.empty))
    else $error("queue status inconsistent");

endmodule
